/* sv/bpc_pkg.sv */
package bpc_pkg;

    typedef enum logic [2:0] {
        CFG_SENS,
        CFG_OFFSET,
        CFG_SENS_TC,
        CFG_OFFSET_TC,
        CFG_REF_TEMP,
        CFG_TEMP_COEFF
    } t_cfg_idx;

    localparam int CFG_IDX_W = 3;
    localparam int CAL_W     = 16;
    localparam int RAW_W     = 24;
    localparam int PRES_W    = 32;
    localparam int TDEC_W    = 16;

    localparam logic signed [19:0] TEMP_REF     = 20'sd2000;
    localparam logic signed [19:0] TEMP_LOW_OFS = 20'sd3500;

    // ceil(2^27 / 10): exact quotient for magnitudes below 2^26
    localparam logic [23:0] RECIP10 = 24'd13421773;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] sens_tc;
        logic [CAL_W-1:0] offset_tc;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] temp_coeff;
    } t_cal;

    typedef struct packed {
        logic [RAW_W-1:0]    d1;
        logic signed [19:0]  temp;
        logic [17:0]         t2;
        logic signed [35:0]  off;
        logic signed [34:0]  sens;
        logic signed [37:0]  sq1;
        logic signed [39:0]  sq2;
        logic                cold;
        logic                frigid;
    } t_mid;

endpackage

/* sv/bpc_cal_regs.sv */
module bpc_cal_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [bpc_pkg::CAL_W-1:0]     i_data,
    output bpc_pkg::t_cal                 o_cal
);

    bpc_pkg::t_cal r_cal;

    assign o_ready = 1'b1;
    assign o_cal   = r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_valid) begin
            unique case (bpc_pkg::t_cfg_idx'(i_index))
                bpc_pkg::CFG_SENS:       r_cal.sens       <= i_data;
                bpc_pkg::CFG_OFFSET:     r_cal.offset     <= i_data;
                bpc_pkg::CFG_SENS_TC:    r_cal.sens_tc    <= i_data;
                bpc_pkg::CFG_OFFSET_TC:  r_cal.offset_tc  <= i_data;
                bpc_pkg::CFG_REF_TEMP:   r_cal.ref_temp   <= i_data;
                bpc_pkg::CFG_TEMP_COEFF: r_cal.temp_coeff <= i_data;
                default: ;
            endcase
        end
    end

endmodule

/* sv/bpc_front.sv */
module bpc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bpc_pkg::t_cal             i_cal,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [bpc_pkg::RAW_W-1:0] i_d1,
    input  logic [bpc_pkg::RAW_W-1:0] i_d2,
    output logic                      o_valid,
    input  logic                      i_ready,
    output bpc_pkg::t_mid             o_mid
);

    logic [3:0] r_v;
    logic [3:0] adv;

    logic [bpc_pkg::RAW_W-1:0] r1_d1, r2_d1, r3_d1;
    logic signed [24:0] r1_dt;
    logic signed [41:0] r2_mt, r2_moff, r2_msens;
    logic signed [49:0] r2_mdd;
    logic signed [18:0] r3_dtemp;
    logic signed [19:0] r3_temp, r3_dlow;
    logic signed [35:0] r3_off;
    logic signed [34:0] r3_sens;
    logic [17:0]        r3_t2;
    bpc_pkg::t_mid      r_s4;

    logic signed [24:0] n1_dt;
    logic signed [41:0] n2_mt, n2_moff, n2_msens;
    logic signed [49:0] n2_mdd;
    logic signed [18:0] n3_dtemp;
    logic signed [19:0] n3_temp, n3_dlow;
    logic signed [35:0] n3_off;
    logic signed [34:0] n3_sens;
    logic signed [37:0] n4_sq1;
    logic signed [39:0] n4_sq2;

    always_comb begin
        adv[3] = !r_v[3] || i_ready;
        adv[2] = !r_v[2] || adv[3];
        adv[1] = !r_v[1] || adv[2];
        adv[0] = !r_v[0] || adv[1];
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[3];
    assign o_mid   = r_s4;

    always_comb begin
        n1_dt    = $signed({1'b0, i_d2}) - $signed({1'b0, i_cal.ref_temp, 8'b0});
        n2_mt    = r1_dt * $signed({1'b0, i_cal.temp_coeff});
        n2_moff  = r1_dt * $signed({1'b0, i_cal.offset_tc});
        n2_msens = r1_dt * $signed({1'b0, i_cal.sens_tc});
        n2_mdd   = r1_dt * r1_dt;
        n3_dtemp = r2_mt[41:23];
        n3_temp  = 20'(n3_dtemp) + bpc_pkg::TEMP_REF;
        n3_dlow  = 20'(n3_dtemp) + bpc_pkg::TEMP_LOW_OFS;
        n3_off   = 36'($signed({1'b0, i_cal.offset, 16'b0})) + 36'($signed(r2_moff[41:7]));
        n3_sens  = 35'($signed({1'b0, i_cal.sens, 15'b0})) + 35'($signed(r2_msens[41:8]));
        n4_sq1   = r3_dtemp * r3_dtemp;
        n4_sq2   = r3_dlow * r3_dlow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_d1 <= i_d1;
            r1_dt <= n1_dt;
        end
        if (adv[1]) begin
            r2_d1    <= r1_d1;
            r2_mt    <= n2_mt;
            r2_moff  <= n2_moff;
            r2_msens <= n2_msens;
            r2_mdd   <= n2_mdd;
        end
        if (adv[2]) begin
            r3_d1    <= r2_d1;
            r3_dtemp <= n3_dtemp;
            r3_temp  <= n3_temp;
            r3_dlow  <= n3_dlow;
            r3_off   <= n3_off;
            r3_sens  <= n3_sens;
            r3_t2    <= r2_mdd[48:31];
        end
        if (adv[3]) begin
            r_s4.d1     <= r3_d1;
            r_s4.temp   <= r3_temp;
            r_s4.t2     <= r3_t2;
            r_s4.off    <= r3_off;
            r_s4.sens   <= r3_sens;
            r_s4.sq1    <= n4_sq1;
            r_s4.sq2    <= n4_sq2;
            r_s4.cold   <= r3_dtemp[18];
            r_s4.frigid <= r3_dlow[19];
        end
    end

endmodule

/* sv/bpc_back.sv */
module bpc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  bpc_pkg::t_mid                     i_mid,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [bpc_pkg::PRES_W-1:0] o_pressure,
    output logic signed [bpc_pkg::TDEC_W-1:0] o_temperature
);

    logic [4:0] r_v;
    logic [4:0] adv;

    logic [bpc_pkg::RAW_W-1:0] r5_d1, r6_d1;
    logic signed [20:0] r5_temp_f;
    logic signed [35:0] r5_off;
    logic signed [34:0] r5_sens;
    logic signed [43:0] r5_off2, r5_sens2;
    logic signed [44:0] r6_off_f, r6_sens_f, r7_off_f, r8_off_f;
    logic [20:0]        r6_tabs;
    logic               r6_tneg, r7_tneg;
    logic [45:0]        r7_pp_lo;
    logic signed [47:0] r7_pp_hi;
    logic [44:0]        r7_qmul;
    logic signed [69:0] r8_prod;
    logic signed [18:0] r8_tdec;
    logic signed [bpc_pkg::PRES_W-1:0] r_p;
    logic signed [bpc_pkg::TDEC_W-1:0] r_t;

    logic signed [43:0] sq1_x, sq2_x, sq1_5, sq2_7, sq2_11;
    logic signed [43:0] n5_off2, n5_sens2;
    logic signed [20:0] n5_temp_f;
    logic [20:0]        n6_tabs;
    logic [17:0]        n8_tq;
    logic signed [18:0] n8_tdec;
    logic signed [69:0] n8_prod;
    logic signed [49:0] n9_pfull;
    logic signed [34:0] n9_p35;
    logic signed [bpc_pkg::PRES_W-1:0] n9_p;
    logic signed [bpc_pkg::TDEC_W-1:0] n9_t;

    always_comb begin
        adv[4] = !r_v[4] || i_ready;
        adv[3] = !r_v[3] || adv[4];
        adv[2] = !r_v[2] || adv[3];
        adv[1] = !r_v[1] || adv[2];
        adv[0] = !r_v[0] || adv[1];
    end

    assign o_ready       = adv[0];
    assign o_valid       = r_v[4];
    assign o_pressure    = r_p;
    assign o_temperature = r_t;

    always_comb begin
        sq1_x  = 44'(i_mid.sq1);
        sq2_x  = 44'(i_mid.sq2);
        sq1_5  = (sq1_x <<< 2) + sq1_x;
        sq2_7  = (sq2_x <<< 3) - sq2_x;
        sq2_11 = (sq2_x <<< 3) + (sq2_x <<< 1) + sq2_x;
        n5_off2  = '0;
        n5_sens2 = '0;
        if (i_mid.cold) begin
            n5_off2  = (sq1_5 >>> 1) + (i_mid.frigid ? sq2_7 : 44'sd0);
            n5_sens2 = (sq1_5 >>> 2) + (i_mid.frigid ? (sq2_11 >>> 1) : 44'sd0);
        end
        n5_temp_f = 21'(i_mid.temp) - (i_mid.cold ? $signed({3'b0, i_mid.t2}) : 21'sd0);

        n6_tabs = r5_temp_f[20] ? 21'(-r5_temp_f) : 21'(r5_temp_f);

        n8_prod = (70'(r7_pp_hi) <<< 22) + $signed({24'b0, r7_pp_lo});
        n8_tq   = r7_qmul[44:27];
        n8_tdec = r7_tneg ? -$signed({1'b0, n8_tq}) : $signed({1'b0, n8_tq});

        n9_pfull = 50'($signed(r8_prod[69:21])) - 50'(r8_off_f);
        n9_p35   = n9_pfull[49:15];
        if (n9_p35[34:31] == {4{n9_p35[31]}}) begin
            n9_p = n9_p35[31:0];
        end else begin
            n9_p = n9_p35[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        if (r8_tdec[18:15] == {4{r8_tdec[15]}}) begin
            n9_t = r8_tdec[15:0];
        end else begin
            n9_t = r8_tdec[18] ? 16'sh8000 : 16'sh7FFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
            if (adv[4]) r_v[4] <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r5_d1     <= i_mid.d1;
            r5_temp_f <= n5_temp_f;
            r5_off    <= i_mid.off;
            r5_sens   <= i_mid.sens;
            r5_off2   <= n5_off2;
            r5_sens2  <= n5_sens2;
        end
        if (adv[1]) begin
            r6_d1     <= r5_d1;
            r6_off_f  <= 45'(r5_off) - 45'(r5_off2);
            r6_sens_f <= 45'(r5_sens) - 45'(r5_sens2);
            r6_tabs   <= n6_tabs;
            r6_tneg   <= r5_temp_f[20];
        end
        if (adv[2]) begin
            r7_pp_lo <= r6_d1 * r6_sens_f[21:0];
            r7_pp_hi <= $signed({1'b0, r6_d1}) * $signed(r6_sens_f[44:22]);
            r7_qmul  <= r6_tabs * bpc_pkg::RECIP10;
            r7_off_f <= r6_off_f;
            r7_tneg  <= r6_tneg;
        end
        if (adv[3]) begin
            r8_prod  <= n8_prod;
            r8_off_f <= r7_off_f;
            r8_tdec  <= n8_tdec;
        end
        if (adv[4]) begin
            r_p <= n9_p;
            r_t <= n9_t;
        end
    end

endmodule

/* sv/baro_pressure_temp_compensation.sv */
// Second-order barometric compensation: each transaction on the slave stream carries a raw
// pressure and temperature reading, and the master stream carries the compensated pressure
// (0.01 mbar) and temperature (0.1 C), both saturated. The datapath is a nine-stage pipeline,
// four stages for offset, sensitivity and squares and five for the corrections, the split
// 70-bit pressure product and the divide by ten, so a new reading is taken every cycle while
// the pipeline is not backed up and up to nine are in flight. Each stage holds its own valid
// bit and moves on when the one after it is free, so a stall on the master side fills bubbles
// before it backs up to o_s_axis_tready. The six calibration words are written on the
// configuration channel, which is always ready; write them only while no reading is in flight.
module baro_pressure_temp_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [47:0]                   i_s_axis_tdata,  // raw_pressure, raw_temperature
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [47:0]                   o_m_axis_tdata,  // pressure_centimbar, temperature_decidegree
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpc_pkg::CAL_W-1:0]     i_cfg_data
);

    bpc_pkg::t_cal cal;
    bpc_pkg::t_mid mid;
    logic          mid_valid;
    logic          mid_ready;
    logic signed [bpc_pkg::PRES_W-1:0] pressure;
    logic signed [bpc_pkg::TDEC_W-1:0] temperature;

    bpc_cal_regs u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cal   (cal)
    );

    bpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (cal),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_d1    (i_s_axis_tdata[23:0]),
        .i_d2    (i_s_axis_tdata[47:24]),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_mid   (mid)
    );

    bpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (mid_valid),
        .o_ready       (mid_ready),
        .i_mid         (mid),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_pressure    (pressure),
        .o_temperature (temperature)
    );

    assign o_m_axis_tdata = {temperature, pressure};

endmodule

/* sv/bpc_checker.sv */
module bpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or dropped");

    // drop all results on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // back-pressure only when the whole pipeline is full behind a stalled result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled while output side free");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam longint WARM_EDGE     = 2000;
    localparam longint FRIGID_EDGE   = -1500;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     QUIET_LIMIT   = 2000;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 192;
    localparam int     TAIL_CYCLES   = 12;
    localparam int     MAX_REPORTS   = 10;

    typedef enum logic [1:0] {
        IDLING_NONE,
        IDLING_SENDER,
        IDLING_RECEIVER,
        IDLING_BOTH
    } t_idling;

    typedef struct packed {
        logic [bpc_pkg::RAW_W-1:0] raw_temperature;
        logic [bpc_pkg::RAW_W-1:0] raw_pressure;
    } t_reading;

    typedef struct packed {
        logic signed [bpc_pkg::TDEC_W-1:0] temperature_decidegree;
        logic signed [bpc_pkg::PRES_W-1:0] pressure_centimbar;
    } t_readout;

    typedef struct packed {
        logic [2:0]                        cal_set;
        logic [bpc_pkg::RAW_W-1:0]         raw_pressure;
        logic [bpc_pkg::RAW_W-1:0]         raw_temperature;
        logic                              fixed_result;
        logic signed [bpc_pkg::PRES_W-1:0] pressure;
        logic signed [bpc_pkg::TDEC_W-1:0] temperature;
    } t_directed_row;

    localparam bpc_pkg::t_cal CAL_SETS [5] = '{
        '{16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312},
        '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF},
        '{16'hFFFF,  16'd0,     16'hFFFF,  16'd0,     16'hFFFF,  16'hFFFF},
        '{16'd0,     16'hFFFF,  16'd0,     16'hFFFF,  16'd0,     16'hFFFF}
    };

    localparam int DIRECTED_COUNT = 22;
    localparam t_directed_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{3'd0, 24'h000000, 24'h000000, 1'b1, 32'sd0, 16'sd200},
        '{3'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'sd0, 16'sd200},
        '{3'd0, 24'hFFFFFF, 24'h000000, 1'b1, 32'sd0, 16'sd200},
        '{3'd0, 24'h000000, 24'hFFFFFF, 1'b1, 32'sd0, 16'sd200},
        '{3'd1, 24'd9085466, 24'd8569150, 1'b0, 32'sd0, 16'sd0},
        '{3'd1, 24'd9085466, 24'd9000000, 1'b0, 32'sd0, 16'sd0},
        '{3'd1, 24'd9085466, 24'd8566784, 1'b0, 32'sd0, 16'sd0},
        '{3'd1, 24'd9085466, 24'd8566783, 1'b0, 32'sd0, 16'sd0},
        '{3'd1, 24'd9085466, 24'd8270784, 1'b0, 32'sd0, 16'sd0},
        '{3'd1, 24'd9085466, 24'd7529764, 1'b0, 32'sd0, 16'sd0},
        '{3'd1, 24'd9085466, 24'd7529763, 1'b0, 32'sd0, 16'sd0},
        '{3'd1, 24'h000000, 24'h000000, 1'b0, 32'sd0, 16'sd0},
        '{3'd1, 24'hFFFFFF, 24'h000000, 1'b0, 32'sd0, 16'sd0},
        '{3'd2, 24'h000000, 24'h000000, 1'b0, 32'sd0, 16'sd0},
        '{3'd2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 32'sd0, 16'sd0},
        '{3'd2, 24'hFFFFFF, 24'h000000, 1'b0, 32'sd0, 16'sd0},
        '{3'd2, 24'h800000, 24'hFFFF00, 1'b0, 32'sd0, 16'sd0},
        '{3'd3, 24'hFFFFFF, 24'h000000, 1'b0, 32'sd0, 16'sd0},
        '{3'd3, 24'h000000, 24'h000000, 1'b0, 32'sd0, 16'sd0},
        '{3'd3, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 32'sd0, 16'sd0},
        '{3'd4, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 32'sd0, 16'sd0},
        '{3'd4, 24'h000000, 24'h000000, 1'b0, 32'sd0, 16'sd0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [47:0]                   i_s_axis_tdata = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [47:0]                   o_m_axis_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [bpc_pkg::CAL_W-1:0]     i_cfg_data = '0;

    bpc_pkg::t_cal cal_now = '0;
    t_readout readouts_due [$];
    t_readout fixed_readout = '0;
    t_readout seen;
    t_readout want;
    logic     use_fixed = 1'b0;
    logic     hold_pending = 1'b0;
    logic     moved;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       quiet_cycles = 0;
    int       error_count = 0;

    baro_pressure_temp_compensation DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // raw_pressure, raw_temperature
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // pressure_centimbar, temperature_decidegree
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_readout compensate(t_reading r, bpc_pkg::t_cal c);
        longint d1, dt, temp, off, sens, t2, off2, sens2, sq, p, tdec;
        t_readout res;
        d1   = longint'(r.raw_pressure);
        dt   = longint'(r.raw_temperature) - longint'(c.ref_temp) * 256;
        temp = WARM_EDGE + ((dt * longint'(c.temp_coeff)) >>> 23);
        off  = longint'(c.offset) * 65536 + ((longint'(c.offset_tc) * dt) >>> 7);
        sens = longint'(c.sens) * 32768 + ((longint'(c.sens_tc) * dt) >>> 8);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < WARM_EDGE) begin
            t2    = (dt * dt) >>> 31;
            sq    = (temp - WARM_EDGE) * (temp - WARM_EDGE);
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (temp < FRIGID_EDGE) begin
                sq    = (temp - FRIGID_EDGE) * (temp - FRIGID_EDGE);
                off2  = off2 + 7 * sq;
                sens2 = sens2 + ((11 * sq) >>> 1);
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        tdec = temp / 10;
        if (tdec > 64'sd32767) tdec = 64'sd32767;
        if (tdec < -64'sd32768) tdec = -64'sd32768;
        res.pressure_centimbar     = p[bpc_pkg::PRES_W-1:0];
        res.temperature_decidegree = tdec[bpc_pkg::TDEC_W-1:0];
        return res;
    endfunction

    function automatic bpc_pkg::t_cal random_cal();
        bpc_pkg::t_cal c;
        logic [bpc_pkg::CAL_W-1:0] w [6];
        for (int i = 0; i < 6; i++) begin
            case ($urandom_range(0, 7))
                0:       w[i] = '0;
                1:       w[i] = '1;
                default: w[i] = bpc_pkg::CAL_W'($urandom);
            endcase
        end
        c.sens       = w[0];
        c.offset     = w[1];
        c.sens_tc    = w[2];
        c.offset_tc  = w[3];
        c.ref_temp   = w[4];
        c.temp_coeff = w[5];
        return c;
    endfunction

    function automatic t_reading random_reading(bpc_pkg::t_cal c);
        t_reading r;
        int pick, base, span, val;
        pick = $urandom_range(0, 9);
        base = int'(c.ref_temp) * 256;
        if ($urandom_range(0, 7) == 0) begin
            r.raw_pressure = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        end else begin
            r.raw_pressure = bpc_pkg::RAW_W'($urandom);
        end
        if (pick == 0) begin
            r.raw_temperature = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        end else if (pick <= 4) begin
            // land near the reference point, where the branch edges sit
            span = $urandom_range(0, 1 << $urandom_range(0, 22));
            val  = $urandom_range(0, 1) ? base + span : base - span;
            if (val < 0) val = 0;
            if (val > 24'hFFFFFF) val = 24'hFFFFFF;
            r.raw_temperature = val[bpc_pkg::RAW_W-1:0];
        end else begin
            r.raw_temperature = bpc_pkg::RAW_W'($urandom);
        end
        return r;
    endfunction

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endtask

    task automatic set_idling(t_idling mode);
        case (mode)
            IDLING_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLING_SENDER:   begin send_idle_pct = 47; recv_stall_pct = 0;  end
            IDLING_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default:         begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    task automatic send_reading(t_reading r);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= r;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        while (readouts_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_calibration(bpc_pkg::t_cal c);
        logic [bpc_pkg::CFG_IDX_W-1:0] regs [8];
        logic [bpc_pkg::CAL_W-1:0]     vals [8];
        regs = '{bpc_pkg::CFG_SENS, bpc_pkg::CFG_OFFSET, bpc_pkg::CFG_SENS_TC,
                 bpc_pkg::CFG_OFFSET_TC, bpc_pkg::CFG_REF_TEMP, bpc_pkg::CFG_TEMP_COEFF,
                 CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI};
        vals = '{c.sens, c.offset, c.sens_tc, c.offset_tc, c.ref_temp, c.temp_coeff,
                 bpc_pkg::CAL_W'($urandom), bpc_pkg::CAL_W'($urandom)};
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                moved = 1'b1;
                seen  = t_readout'(o_m_axis_tdata);
                if (readouts_due.size() == 0) begin
                    log_error($sformatf("unexpected transaction: pressure %0d, temperature %0d",
                        seen.pressure_centimbar, seen.temperature_decidegree));
                end else begin
                    want = readouts_due.pop_front();
                    if (seen.pressure_centimbar !== want.pressure_centimbar) begin
                        log_error($sformatf("pressure_centimbar: expected %0d, got %0d",
                            want.pressure_centimbar, seen.pressure_centimbar));
                    end
                    if (seen.temperature_decidegree !== want.temperature_decidegree) begin
                        log_error($sformatf("temperature_decidegree: expected %0d, got %0d",
                            want.temperature_decidegree, seen.temperature_decidegree));
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                moved = 1'b1;
                readouts_due.push_back(use_fixed ? fixed_readout
                    : compensate(t_reading'(i_s_axis_tdata), cal_now));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    bpc_pkg::CFG_SENS:       cal_now.sens       = i_cfg_data;
                    bpc_pkg::CFG_OFFSET:     cal_now.offset     = i_cfg_data;
                    bpc_pkg::CFG_SENS_TC:    cal_now.sens_tc    = i_cfg_data;
                    bpc_pkg::CFG_OFFSET_TC:  cal_now.offset_tc  = i_cfg_data;
                    bpc_pkg::CFG_REF_TEMP:   cal_now.ref_temp   = i_cfg_data;
                    bpc_pkg::CFG_TEMP_COEFF: cal_now.temp_coeff = i_cfg_data;
                    default: ;
                endcase
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_reading reading;
        int       set_now;
        set_now = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_idling(IDLING_NONE);
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            if (int'(DIRECTED_ROWS[i].cal_set) != set_now) begin
                drain_pipeline();
                set_now = int'(DIRECTED_ROWS[i].cal_set);
                load_calibration(CAL_SETS[set_now]);
            end
            use_fixed = DIRECTED_ROWS[i].fixed_result;
            fixed_readout.pressure_centimbar     = DIRECTED_ROWS[i].pressure;
            fixed_readout.temperature_decidegree = DIRECTED_ROWS[i].temperature;
            reading.raw_pressure    = DIRECTED_ROWS[i].raw_pressure;
            reading.raw_temperature = DIRECTED_ROWS[i].raw_temperature;
            send_reading(reading);
        end
        use_fixed = 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pipeline();
            load_calibration(random_cal());
            set_idling(t_idling'(ph % 4));
            // back up the output side while the input keeps offering
            if (ph == 4) hold_pending = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_reading(random_reading(cal_now));
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && readouts_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
